FILE: hdl/kf3_pkg.sv
// Shared types and constants of the three-axis Kalman filter.
`timescale 1ns / 1ps
package kf3_pkg;

    localparam int AXES      = 3;
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int GAIN_W    = FRAC_BITS + 1;
    localparam int AXIS_W    = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int DIV_STEPS = GAIN_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W = 2;

    localparam logic [GAIN_W-1:0] ONE_FX = GAIN_W'(1) << FRAC_BITS;

    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = CFG_IDX_W'(1);

    localparam logic [DATA_W-1:0] PROCESS_NOISE_RST = DATA_W'(65536);
    localparam logic [DATA_W-1:0] MEASURE_NOISE_RST = DATA_W'(65536);

    typedef struct packed {
        logic signed [DATA_W-1:0] obs_x;
        logic signed [DATA_W-1:0] obs_y;
        logic signed [DATA_W-1:0] obs_z;
    } obs_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] est_x;
        logic signed [DATA_W-1:0] est_y;
        logic signed [DATA_W-1:0] est_z;
        logic        [GAIN_W-1:0] gain;
    } res_t;

    // controller -> datapath
    typedef struct packed {
        logic              accept;
        logic              prep;
        logic              div_step;
        logic              mul;
        logic              acc;
        logic              cmul;
        logic              cupd;
        logic              emit;
        logic [AXIS_W-1:0] axis;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
    } sts_t;

endpackage

FILE: hdl/kalman_filter_3axis_identity.sv
// Top level of the three-axis constant-position Kalman filter.
// One item at a time: the input stays closed through intake, set-up, the 17-step restoring
// gain divider, a multiply and an accumulate per axis on the shared update multiplier, the
// p update and output, and it stays closed while the output stalls.
// Reset: estimates and covariance to zero, q and r to 1.0, no result pending.
`timescale 1ns / 1ps
module kalman_filter_3axis_identity (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            obs_valid,
    output logic                            obs_stall,
    input  kf3_pkg::obs_t                   obs,
    output logic                            res_valid,
    input  logic                            res_stall,
    output kf3_pkg::res_t                   res,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [kf3_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kf3_pkg::DATA_W-1:0]      cfg_data
);
    import kf3_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // registers are always writable; indexes past the list are dropped
    assign cfg_ready = 1'b1;

    // sequencer: one item at a time, prior -> gain division -> per-axis
    // update -> covariance update -> output register
    kf3_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .obs_valid (obs_valid),
        .obs_stall (obs_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath holds q, r, p and the estimates; the output register lets
    // the next item enter while a result still waits downstream
    kf3_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .obs       (obs),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    // gain never goes above one
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.gain <= ONE_FX))
        else $error("gain above one");

    // an accepted item keeps the input closed while it is worked on
    assert property (@(posedge clk) disable iff (!rst_n)
        (obs_valid && !obs_stall) |=> obs_stall)
        else $error("input reopened during item");

    // a new result only comes from an item in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(obs_stall))
        else $error("result without item");

    // no division, update or output command is issued while the sequencer waits for input
    assert property (@(posedge clk) disable iff (!rst_n)
        !obs_stall |-> !(cmd.div_step || cmd.acc || cmd.cupd || cmd.emit))
        else $error("datapath command while idle");

endmodule

FILE: hdl/kf3_ctrl.sv
// Sequencer of the Kalman filter: steps the datapath through one item.
`timescale 1ns / 1ps
module kf3_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          obs_valid,
    output logic          obs_stall,
    input  kf3_pkg::sts_t sts,
    output kf3_pkg::cmd_t cmd
);
    import kf3_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_ACC  = 3'd4;
    localparam logic [2:0] ST_CMUL = 3'd5;
    localparam logic [2:0] ST_CUPD = 3'd6;
    localparam logic [2:0] ST_EMIT = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [AXIS_W-1:0] axis_reg, axis_next;

    assign obs_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        axis_next  = axis_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (obs_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    axis_next  = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
                if (axis_reg == AXIS_W'(AXES - 1))
                    state_next = ST_CMUL;
                else
                begin
                    axis_next  = axis_reg + AXIS_W'(1);
                    state_next = ST_MUL;
                end
            end
            ST_CMUL:
            begin
                cmd.cmul   = 1'b1;
                state_next = ST_CUPD;
            end
            ST_CUPD:
            begin
                cmd.cupd   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            axis_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            axis_reg  <= axis_next;
        end
    end

endmodule

FILE: hdl/kf3_dp.sv
// Datapath of the Kalman filter: state, gain divider, update multiplier, output register.
`timescale 1ns / 1ps
module kf3_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  kf3_pkg::cmd_t                   cmd,
    output kf3_pkg::sts_t                   sts,
    input  kf3_pkg::obs_t                   obs,
    input  logic                            cfg_wr,
    input  logic [kf3_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kf3_pkg::DATA_W-1:0]      cfg_data,
    output logic                            res_valid,
    input  logic                            res_stall,
    output kf3_pkg::res_t                   res
);
    import kf3_pkg::*;

    localparam int DEN_W  = DATA_W + 1;
    localparam int REM_W  = DATA_W + 2;
    localparam int DIFF_W = DATA_W + 1;
    localparam int PROD_W = DIFF_W + GAIN_W + 1;
    localparam int CPR_W  = DATA_W + GAIN_W;
    localparam int NE_W   = DATA_W + 4;

    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [NE_W-1:0]   EST_MAX    = NE_W'(32'h7FFF_FFFF);
    localparam logic signed [NE_W-1:0]   EST_MIN    = -(NE_W'(33'h1_0000_0000) >>> 1);

    // configuration and filter state
    logic        [DATA_W-1:0] q_reg, r_reg, cov_reg;
    logic signed [DATA_W-1:0] est_reg [AXES];

    // per-item working registers
    logic signed [DATA_W-1:0] z_reg [AXES];
    logic        [DATA_W-1:0] pm_reg;
    logic        [DEN_W-1:0]  den_reg;
    logic                     den_zero_reg;
    logic        [REM_W-1:0]  rem_reg;
    logic        [GAIN_W-1:0] quot_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic        [CPR_W-1:0]  cprod_reg;
    res_t                     res_reg;
    logic                     res_valid_reg;

    logic [DATA_W:0]          pm_sum;
    logic [DATA_W-1:0]        pm_next;
    logic [DEN_W-1:0]         den_next;
    logic                     rem_ge;
    logic [REM_W-1:0]         rem_sel;
    logic [GAIN_W-1:0]        k_eff;
    logic signed [DATA_W-1:0] z_sel, e_sel;
    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] delta_wide;
    logic signed [NE_W-1:0]   ne_wide;
    logic signed [DATA_W-1:0] ne_clamp;
    logic [CPR_W-1:0]         cprod_next;

    // prior covariance, saturating
    assign pm_sum  = {1'b0, cov_reg} + {1'b0, q_reg};
    assign pm_next = pm_sum[DATA_W] ? '1 : pm_sum[DATA_W-1:0];
    assign den_next = {1'b0, pm_reg} + {1'b0, r_reg};

    // restoring divider, one quotient bit a step
    assign rem_ge  = (rem_reg >= REM_W'(den_reg));
    assign rem_sel = rem_ge ? (rem_reg - REM_W'(den_reg)) : rem_reg;

    assign k_eff = den_zero_reg ? ONE_FX : quot_reg;

    // innovation times gain on the selected axis
    assign z_sel     = z_reg[cmd.axis];
    assign e_sel     = est_reg[cmd.axis];
    assign diff      = DIFF_W'(z_sel) - DIFF_W'(e_sel);
    assign prod_next = PROD_W'(diff) * $signed({1'b0, k_eff});

    // round half up, then clamp to the signed range
    assign delta_wide = (prod_reg + ROUND_HALF) >>> FRAC_BITS;
    assign ne_wide    = NE_W'(e_sel) + delta_wide[NE_W-1:0];
    always_comb
    begin
        if (ne_wide > EST_MAX)
            ne_clamp = EST_MAX[DATA_W-1:0];
        else if (ne_wide < EST_MIN)
            ne_clamp = EST_MIN[DATA_W-1:0];
        else
            ne_clamp = ne_wide[DATA_W-1:0];
    end

    assign cprod_next = CPR_W'(ONE_FX - k_eff) * CPR_W'(pm_reg);

    assign sts.out_free = !res_valid_reg || !res_stall;
    assign res_valid    = res_valid_reg;
    assign res          = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg         <= PROCESS_NOISE_RST;
            r_reg         <= MEASURE_NOISE_RST;
            cov_reg       <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < AXES; i++)
                est_reg[i] <= '0;
        end
        else
        begin
            if (cfg_wr && cfg_index == REG_PROCESS_NOISE)
                q_reg <= cfg_data;
            if (cfg_wr && cfg_index == REG_MEASURE_NOISE)
                r_reg <= cfg_data;
            if (cmd.acc)
                est_reg[cmd.axis] <= ne_clamp;
            if (cmd.cupd)
                cov_reg <= cprod_reg[FRAC_BITS +: DATA_W];
            if (cmd.emit)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            z_reg[0] <= obs.obs_x;
            z_reg[1] <= obs.obs_y;
            z_reg[2] <= obs.obs_z;
            pm_reg   <= pm_next;
        end
        if (cmd.prep)
        begin
            den_reg      <= den_next;
            den_zero_reg <= (den_next == '0);
            rem_reg      <= REM_W'(pm_reg);
            quot_reg     <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg  <= {rem_sel[REM_W-2:0], 1'b0};
            quot_reg <= {quot_reg[GAIN_W-2:0], rem_ge};
        end
        if (cmd.mul)
            prod_reg <= prod_next;
        if (cmd.cmul)
            cprod_reg <= cprod_next;
        if (cmd.emit)
        begin
            res_reg.est_x <= est_reg[0];
            res_reg.est_y <= est_reg[1];
            res_reg.est_z <= est_reg[2];
            res_reg.gain  <= k_eff;
        end
    end

endmodule

FILE: dv/kalman_filter_3axis_identity_tb.sv
// Self-checking bench for the three-axis Kalman filter: directed table, then random phases.
`timescale 1ns / 1ps
module kalman_filter_3axis_identity_tb;
    import kf3_pkg::*;

    // Indexes past the two noise registers; the block must ignore writes to them.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = CFG_IDX_W'(3);

    localparam longint UNITY   = longint'(1) << FRAC_BITS;
    localparam longint VAR_MAX = 64'h0000_0000_FFFF_FFFF;
    localparam longint EST_MAX = 64'sd2147483647;
    localparam longint EST_MIN = -64'sd2147483648;

    localparam logic [DATA_W-1:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] POS_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] VAR_TOP = 32'hFFFF_FFFF;
    localparam logic [GAIN_W-1:0] GAIN_HALF = ONE_FX >> 1;

    localparam int TARGET_ITEMS  = 1400;
    // Idle time after the last result is back, before the verdict.
    localparam int SETTLE_CYCLES = 40;
    localparam int DIR_ROWS      = 17;

    logic  clk;
    logic  rst_n;
    logic  obs_valid;
    logic  obs_stall;
    obs_t  obs;
    logic  res_valid;
    logic  res_stall;
    res_t  res;
    logic  cfg_valid;
    logic  cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;

    kalman_filter_3axis_identity dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .obs_valid (obs_valid),
        .obs_stall (obs_stall),
        .obs       (obs),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // One row of the directed table. A row with retune set drains the block and
    // loads new q and r before its item. Where typed is set the expected result is
    // written out by hand; otherwise the filter model supplies it.
    typedef struct packed {
        logic              retune;
        logic [DATA_W-1:0] q;
        logic [DATA_W-1:0] r;
        obs_t              obs;
        logic              typed;
        res_t              want;
    } step_row_t;

    // Notes on the hand-written rows:
    //  - straight after reset (q = r = 1.0, p = 0) a zero item gives gain one half;
    //  - with r = 0 the gain is exactly one, so the estimate snaps to the item,
    //    and p drops to zero; with q = 0 as well the denominator is zero and the
    //    gain is forced to one;
    //  - q = r = max from p = 0 gives gain one half, and an item equal to the
    //    current estimate leaves it untouched. The next items push p + q past
    //    its maximum, so the prior saturates.
    step_row_t dir_tab [DIR_ROWS] = '{
        '{1'b0, '0, '0, '{'0, '0, '0}, 1'b1, '{'0, '0, '0, GAIN_HALF}},
        '{1'b0, '0, '0, '{POS_MAX, POS_MIN, 32'h0001_0000}, 1'b0, '0},
        '{1'b0, '0, '0, '{POS_MIN, POS_MAX, 32'hFFFF_FFFF}, 1'b0, '0},
        '{1'b1, '0, '0, '{POS_MAX, POS_MIN, '0}, 1'b1, '{POS_MAX, POS_MIN, '0, ONE_FX}},
        '{1'b0, '0, '0, '{POS_MIN, POS_MAX, 32'hFFFF_FFFF}, 1'b1,
          '{POS_MIN, POS_MAX, 32'hFFFF_FFFF, ONE_FX}},
        '{1'b0, '0, '0, '{'0, '0, '0}, 1'b1, '{'0, '0, '0, ONE_FX}},
        '{1'b0, '0, '0, '{32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001}, 1'b1,
          '{32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001, ONE_FX}},
        '{1'b0, '0, '0, '{32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_0000}, 1'b1,
          '{32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_0000, ONE_FX}},
        '{1'b1, VAR_TOP, VAR_TOP, '{32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_0000}, 1'b1,
          '{32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_0000, GAIN_HALF}},
        '{1'b0, '0, '0, '{POS_MAX, POS_MIN, '0}, 1'b0, '0},
        '{1'b0, '0, '0, '{POS_MIN, POS_MAX, 32'h0000_8000}, 1'b0, '0},
        '{1'b1, '0, VAR_TOP, '{POS_MAX, POS_MAX, POS_MAX}, 1'b0, '0},
        '{1'b0, '0, '0, '{POS_MIN, POS_MIN, POS_MIN}, 1'b0, '0},
        '{1'b1, VAR_TOP, '0, '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_8000}, 1'b1,
          '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_8000, ONE_FX}},
        '{1'b1, 32'h0000_0001, 32'h0000_0001, '{32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F},
          1'b0, '0},
        '{1'b0, '0, '0, '{32'hFEDC_BA98, 32'h0123_4567, 32'hF0F0_F0F0}, 1'b0, '0},
        '{1'b1, 32'h0001_0000, 32'h0004_0000, '{32'h0001_0000, 32'hFFFF_0000, 32'h0000_0000},
          1'b0, '0}
    };

    // Filter model state, kept in step with the block.
    logic signed [DATA_W-1:0] est_track [AXES];
    logic        [DATA_W-1:0] cov_track;
    logic        [DATA_W-1:0] q_noise;
    logic        [DATA_W-1:0] r_noise;

    res_t pending_est_q [$];
    int   errors;
    int   items_sent;
    int   drift [AXES];
    bit   tx_quiet;
    bit   rx_quiet;

    // ------------------------------------------------------------------
    // Filter model: one measurement in, one estimate set and gain out.
    // ------------------------------------------------------------------
    function automatic res_t filter_step(obs_t o);
        longint z [AXES];
        longint pm;
        longint den;
        longint k;
        longint delta;
        longint upd;
        res_t   r;
        z[0] = longint'(o.obs_x);
        z[1] = longint'(o.obs_y);
        z[2] = longint'(o.obs_z);
        // prior, saturated at the top of its 32-bit range
        pm = longint'(cov_track) + longint'(q_noise);
        if (pm > VAR_MAX)
            pm = VAR_MAX;
        // gain, floor of pm / (pm + r); zero denominator means gain one
        den = pm + longint'(r_noise);
        k = (den == 0) ? UNITY : (pm <<< FRAC_BITS) / den;
        if (k > UNITY)
            k = UNITY;
        // innovation step, rounded to nearest with ties upward, then clamped
        for (int a = 0; a < AXES; a++)
        begin
            delta = ((z[a] - longint'(est_track[a])) * k + (UNITY >>> 1)) >>> FRAC_BITS;
            upd = longint'(est_track[a]) + delta;
            if (upd > EST_MAX)
                upd = EST_MAX;
            else if (upd < EST_MIN)
                upd = EST_MIN;
            est_track[a] = upd[DATA_W-1:0];
        end
        cov_track = DATA_W'(((UNITY - k) * pm) >>> FRAC_BITS);
        r.est_x = est_track[0];
        r.est_y = est_track[1];
        r.est_z = est_track[2];
        r.gain  = k[GAIN_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random stimulus
    // ------------------------------------------------------------------
    // Half the time a slowly wandering target with measurement noise, as a tracker would
    // see; the rest is full-range noise, extremes and tiny values of either sign.
    function automatic obs_t random_obs();
        logic [DATA_W-1:0] v [AXES];
        int mode;
        mode = $urandom_range(0, 9);
        for (int a = 0; a < AXES; a++)
        begin
            if (mode < 5)
            begin
                drift[a] += int'($urandom_range(0, 32'h0000_FFFF)) - 32'sh0000_8000;
                v[a] = DATA_W'(drift[a] + int'($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000);
            end
            else if (mode < 8)
                v[a] = $urandom;
            else if (mode == 8)
            begin
                case ($urandom_range(0, 4))
                    0:       v[a] = POS_MAX;
                    1:       v[a] = POS_MIN;
                    2:       v[a] = '0;
                    3:       v[a] = '1;
                    default: v[a] = DATA_W'(1);
                endcase
            end
            else
                v[a] = DATA_W'(int'($urandom_range(0, 511)) - 256);
        end
        return '{v[0], v[1], v[2]};
    endfunction

    function automatic logic [DATA_W-1:0] random_noise();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return VAR_TOP;
            2:       return DATA_W'($urandom_range(1, 32'h0004_0000));
            3:       return DATA_W'($urandom_range(0, 255));
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic compare_field(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    task automatic check_result(res_t got);
        res_t want;
        if (pending_est_q.size() == 0)
        begin
            $error("result with no item outstanding: %h", got);
            errors++;
        end
        else
        begin
            want = pending_est_q.pop_front();
            compare_field("est_x", longint'(want.est_x), longint'(got.est_x));
            compare_field("est_y", longint'(want.est_y), longint'(got.est_y));
            compare_field("est_z", longint'(want.est_z), longint'(got.est_z));
            compare_field("gain", longint'(want.gain), longint'(got.gain));
        end
    endtask

    // ------------------------------------------------------------------
    // Drivers. All called at a falling edge and return at a falling edge.
    // ------------------------------------------------------------------
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        if (idx == REG_PROCESS_NOISE)
            q_noise = val;
        else if (idx == REG_MEASURE_NOISE)
            r_noise = val;
        @(negedge clk);
    endtask

    // Hold off the sender until every outstanding result is back.
    task automatic wait_all_results();
        obs_valid <= 1'b0;
        while (pending_est_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // New q and r, only once the block is idle; then two writes that must be ignored.
    task automatic retune(logic [DATA_W-1:0] q, logic [DATA_W-1:0] r);
        wait_all_results();
        write_reg(REG_PROCESS_NOISE, q);
        write_reg(REG_MEASURE_NOISE, r);
        write_reg(REG_UNUSED_2, $urandom);
        write_reg(REG_UNUSED_3, $urandom);
        cfg_valid <= 1'b0;
    endtask

    // Present one item after a random gap. valid is left high on return, so the
    // caller either presents the next item or drops valid in the same step.
    task automatic send_obs(obs_t o, bit typed, res_t want);
        int   gap;
        res_t predicted;
        gap = tx_quiet ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            obs_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        obs       <= o;
        obs_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (obs_stall);
        // model always advances, even where the row gives the answer by hand
        predicted = filter_step(o);
        pending_est_q.push_back(typed ? want : predicted);
        items_sent++;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Clock, result side, watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: each result may be held off by a random stall while valid, apart from
    // stretches with no stall at all. Stall is set at the falling edge, so it can
    // land anywhere in the block's work, not only while a result waits.
    initial
    begin : result_side
        int hold;
        hold      = 0;
        rx_quiet  = 1'b0;
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid)
            begin
                if (!res_stall)
                begin
                    check_result(res);
                    if ($urandom_range(0, 79) == 0)
                        rx_quiet = !rx_quiet;
                    hold = rx_quiet ? 0 : $urandom_range(0, 9);
                end
                else if (hold > 0)
                    hold--;
            end
            @(negedge clk);
            res_stall <= (hold != 0);
        end
    end

    // Watchdog: ends the run with an error verdict if the main sequence does not finish.
    initial
    begin
        #5_000_000;
        $display("kalman_filter_3axis_identity_tb: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n     <= 1'b0;
        obs_valid <= 1'b0;
        obs       <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        errors     = 0;
        items_sent = 0;
        tx_quiet   = 1'b0;
        q_noise    = PROCESS_NOISE_RST;
        r_noise    = MEASURE_NOISE_RST;
        cov_track  = '0;
        foreach (est_track[a])
        begin
            est_track[a] = '0;
            drift[a]     = 0;
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Stray writes before the first item: the reset values of q and r must
        // survive, which the first table row shows.
        write_reg(REG_UNUSED_2, $urandom);
        write_reg(REG_UNUSED_3, $urandom);
        cfg_valid <= 1'b0;

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].retune)
                retune(dir_tab[i].q, dir_tab[i].r);
            send_obs(dir_tab[i].obs, dir_tab[i].typed, dir_tab[i].want);
        end

        // Random phases: each one drains the block, picks fresh noise settings and
        // a sender pace, then streams items. Now and then the sender also waits
        // for every result to come back mid-phase.
        while (items_sent < DIR_ROWS + TARGET_ITEMS)
        begin
            retune(random_noise(), random_noise());
            tx_quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0)
            begin
                foreach (drift[a])
                    drift[a] = $urandom;
            end
            repeat ($urandom_range(30, 150))
            begin
                if ($urandom_range(0, 59) == 0)
                    wait_all_results();
                send_obs(random_obs(), 1'b0, '0);
            end
        end

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("kalman_filter_3axis_identity_tb: clean");
        else
            $display("kalman_filter_3axis_identity_tb: errors");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/kf3_pkg.sv
hdl/kf3_ctrl.sv
hdl/kf3_dp.sv
hdl/kalman_filter_3axis_identity.sv
dv/kalman_filter_3axis_identity_tb.sv
